// ----- src/lsg_pkg.sv -----
// shared types and constants of the laplace grid relaxation engine
`timescale 1ns / 1ps
`default_nettype none

package lsg_pkg;

    localparam int DATA_W   = 32;
    localparam int CHG_W    = 40;
    localparam int CNT_W    = 16;
    localparam int OMEGA_W  = 15;
    localparam int KIND_W   = 2;
    localparam int COORD_W  = 4;
    localparam int CFG_IDX_W = 2;

    localparam int DEF_COLS = 16;
    localparam int DEF_ROWS = 16;

    localparam logic [OMEGA_W-1:0] OMEGA_RST = 15'd31130;
    localparam logic [CNT_W-1:0]   MAX_RST   = 16'd10000;
    localparam logic [CHG_W-1:0]   TOL_RST   = 40'd1;
    localparam logic [CHG_W-1:0]   CHG_MAX   = {CHG_W{1'b1}};

    localparam logic [CFG_IDX_W-1:0] CFG_OMEGA = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_TOL   = 2'd2;

    typedef enum logic [KIND_W-1:0] {
        KIND_WRITE = 2'd0,
        KIND_SOLVE = 2'd1,
        KIND_READ  = 2'd2
    } t_kind;

    typedef struct packed {
        logic cap_uw;
        logic cap_ns;
        logic cap_e;
        logic mul;
        logic upd;
        logic acc;
        logic clr_sum;
    } t_upd_ctl;

endpackage

`default_nettype wire

// ----- src/laplace_sor_grid_solver.sv -----
// top level: command decode, grid clearing, sweep sequencer and result registers
`timescale 1ns / 1ps
`default_nettype none

// Grid relaxation engine on a GRID_ROWS x GRID_COLS grid of signed Q16.16 cells held in one
// dual-read memory. After reset a clearing pass zeroes every address of the store with busy high;
// configuration writes are taken throughout. Cell writes and reads are accepted in any cycle
// with busy low and each gives one result strobe on o_valid in the next cycle. A solve with a
// nonzero sweep limit keeps busy high: each interior cell passes three memory read slots on two
// read ports, neighbor sum, multiply, round and saturate and write back, each sweep ends in a
// check state, and the solve result is strobed in the cycle after the last sweep. Results are
// presented for exactly one cycle and cannot be held off.
module laplace_sor_grid_solver import lsg_pkg::*; #(
    parameter int GRID_COLS = DEF_COLS,
    parameter int GRID_ROWS = DEF_ROWS
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_rst_n,
    input  wire logic                     start,
    output logic                          busy,
    input  wire logic        [KIND_W-1:0] i_kind,
    input  wire logic        [COORD_W-1:0] i_col,
    input  wire logic        [COORD_W-1:0] i_row,
    input  wire logic signed [DATA_W-1:0] i_cell_value,
    output logic                          o_valid,
    output logic signed      [DATA_W-1:0] o_read_value,
    output logic             [CNT_W-1:0]  o_sweeps_done,
    output logic                          o_converged,
    output logic             [CHG_W-1:0]  o_final_change,
    input  wire logic                     i_cfg_valid,
    output logic                          o_cfg_ready,
    input  wire logic        [CFG_IDX_W-1:0] i_cfg_index,
    input  wire logic        [CHG_W-1:0]  i_cfg_data
);

    localparam int CW = $clog2(GRID_COLS);
    localparam int RW = $clog2(GRID_ROWS);
    localparam int AW = CW + RW;

    localparam logic [CW-1:0] COL_FIRST = CW'(1);
    localparam logic [CW-1:0] COL_LAST  = CW'(GRID_COLS - 2);
    localparam logic [RW-1:0] ROW_FIRST = RW'(1);
    localparam logic [RW-1:0] ROW_LAST  = RW'(GRID_ROWS - 2);

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_RD0,
        S_RD1,
        S_RD2,
        S_ADD,
        S_MUL,
        S_UPD,
        S_WB,
        S_CHK
    } t_state;

    t_state             r_state;
    logic [AW-1:0]      r_clr;
    logic [RW-1:0]      r_row;
    logic [CW-1:0]      r_col;
    logic [OMEGA_W-1:0] r_omega;
    logic [CNT_W-1:0]   r_max;
    logic [CHG_W-1:0]   r_tol;
    logic [CNT_W-1:0]   r_nsw;
    logic [CNT_W-1:0]   r_sweeps;
    logic               r_conv;
    logic [CHG_W-1:0]   r_change;
    logic               r_valid;
    logic               r_out_rd;

    logic               accept;
    logic               in_grid;
    logic [AW-1:0]      in_addr;
    logic [RW-1:0]      row_m1;
    logic [RW-1:0]      row_p1;
    logic [CW-1:0]      col_m1;
    logic [CW-1:0]      col_p1;
    logic [AW-1:0]      raddr_a;
    logic [AW-1:0]      raddr_b;
    logic               we;
    logic [AW-1:0]      waddr;
    logic [DATA_W-1:0]  wdata;
    logic [DATA_W-1:0]  rdata_a;
    logic [DATA_W-1:0]  rdata_b;
    logic signed [DATA_W-1:0] new_val;
    logic [CHG_W-1:0]   sum;
    logic [CNT_W-1:0]   sweep_next;
    logic               met;
    logic               finish;
    logic               solve_go;
    t_upd_ctl           ctl;

    assign busy        = (r_state != S_IDLE);
    assign accept      = start && !busy;
    assign in_grid     = (int'(i_col) < GRID_COLS) && (int'(i_row) < GRID_ROWS);
    assign in_addr     = {RW'(i_row), CW'(i_col)};
    assign row_m1      = r_row - RW'(1);
    assign row_p1      = r_row + RW'(1);
    assign col_m1      = r_col - CW'(1);
    assign col_p1      = r_col + CW'(1);
    assign solve_go    = accept && (i_kind == KIND_SOLVE) && (r_max != '0);
    assign sweep_next  = r_nsw + CNT_W'(1);
    assign met         = (sum < r_tol);
    assign finish      = met || (sweep_next == r_max);
    assign o_cfg_ready = 1'b1;

    // read slots: center and west, north and south, east
    always_comb begin
        unique case (r_state)
            S_RD0: begin
                raddr_a = {r_row, r_col};
                raddr_b = {r_row, col_m1};
            end
            S_RD1: begin
                raddr_a = {row_m1, r_col};
                raddr_b = {row_p1, r_col};
            end
            S_RD2: begin
                raddr_a = {r_row, col_p1};
                raddr_b = {r_row, r_col};
            end
            default: begin
                raddr_a = in_addr;
                raddr_b = in_addr;
            end
        endcase
    end

    always_comb begin
        priority if (r_state == S_CLEAR) begin
            we    = 1'b1;
            waddr = r_clr;
            wdata = '0;
        end else if (r_state == S_WB) begin
            we    = 1'b1;
            waddr = {r_row, r_col};
            wdata = new_val;
        end else begin
            we    = accept && (i_kind == KIND_WRITE) && in_grid;
            waddr = in_addr;
            wdata = i_cell_value;
        end
    end

    always_comb begin
        ctl.cap_uw  = (r_state == S_RD1);
        ctl.cap_ns  = (r_state == S_RD2);
        ctl.cap_e   = (r_state == S_ADD);
        ctl.mul     = (r_state == S_MUL);
        ctl.upd     = (r_state == S_UPD);
        ctl.acc     = (r_state == S_WB);
        ctl.clr_sum = solve_go || ((r_state == S_CHK) && !finish);
    end

    lsg_grid_mem #(
        .AW (AW)
    ) u_mem (
        .i_clk     (i_clk),
        .i_we      (we),
        .i_waddr   (waddr),
        .i_wdata   (wdata),
        .i_raddr_a (raddr_a),
        .i_raddr_b (raddr_b),
        .o_rdata_a (rdata_a),
        .o_rdata_b (rdata_b)
    );

    lsg_cell_update u_upd (
        .i_clk     (i_clk),
        .i_ctl     (ctl),
        .i_rdata_a (rdata_a),
        .i_rdata_b (rdata_b),
        .i_omega   (r_omega),
        .o_new     (new_val),
        .o_sum     (sum)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_CLEAR;
            r_clr    <= '0;
            r_row    <= ROW_FIRST;
            r_col    <= COL_FIRST;
            r_omega  <= OMEGA_RST;
            r_max    <= MAX_RST;
            r_tol    <= TOL_RST;
            r_nsw    <= '0;
            r_sweeps <= '0;
            r_conv   <= 1'b0;
            r_change <= '0;
            r_valid  <= 1'b0;
            r_out_rd <= 1'b0;
        end else begin
            r_valid  <= (accept && !solve_go) || ((r_state == S_CHK) && finish);
            r_out_rd <= accept && (i_kind == KIND_READ) && in_grid;
            if (i_cfg_valid) begin
                unique case (i_cfg_index)
                    CFG_OMEGA: r_omega <= i_cfg_data[OMEGA_W-1:0];
                    CFG_MAX:   r_max   <= i_cfg_data[CNT_W-1:0];
                    CFG_TOL:   r_tol   <= i_cfg_data;
                    default:   ;
                endcase
            end
            unique case (r_state)
                S_CLEAR: begin
                    r_clr <= r_clr + AW'(1);
                    if (r_clr == '1) begin
                        r_state <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (accept) begin
                        if (i_kind == KIND_SOLVE) begin
                            if (r_max == '0) begin
                                r_sweeps <= '0;
                                r_conv   <= 1'b0;
                                r_change <= '0;
                            end else begin
                                r_nsw   <= '0;
                                r_row   <= ROW_FIRST;
                                r_col   <= COL_FIRST;
                                r_state <= S_RD0;
                            end
                        end
                    end
                end
                S_RD0: r_state <= S_RD1;
                S_RD1: r_state <= S_RD2;
                S_RD2: r_state <= S_ADD;
                S_ADD: r_state <= S_MUL;
                S_MUL: r_state <= S_UPD;
                S_UPD: r_state <= S_WB;
                S_WB: begin
                    if (r_col == COL_LAST) begin
                        r_col <= COL_FIRST;
                        if (r_row == ROW_LAST) begin
                            r_state <= S_CHK;
                        end else begin
                            r_row   <= r_row + RW'(1);
                            r_state <= S_RD0;
                        end
                    end else begin
                        r_col   <= col_p1;
                        r_state <= S_RD0;
                    end
                end
                S_CHK: begin
                    if (finish) begin
                        r_sweeps <= sweep_next;
                        r_conv   <= met;
                        r_change <= sum;
                        r_state  <= S_IDLE;
                    end else begin
                        r_nsw   <= sweep_next;
                        r_row   <= ROW_FIRST;
                        r_col   <= COL_FIRST;
                        r_state <= S_RD0;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_valid        = r_valid;
    assign o_read_value   = r_out_rd ? $signed(rdata_a) : '0;
    assign o_sweeps_done  = r_sweeps;
    assign o_converged    = r_conv;
    assign o_final_change = r_change;

`ifndef SYNTHESIS
    a_result_when_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !busy)
        else $error("result strobe while busy");

    a_access_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && (i_kind != KIND_SOLVE)) |=> o_valid)
        else $error("cell request without a result in the next cycle");

    a_converged_below_tol: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_converged && ($past(r_state) == S_CHK)) |-> (o_final_change < r_tol))
        else $error("converged flag with change not below tolerance");
`endif

endmodule

`default_nettype wire

// ----- src/lsg_grid_mem.sv -----
// grid store: one write port, two registered read ports
`timescale 1ns / 1ps
`default_nettype none

module lsg_grid_mem import lsg_pkg::*; #(
    parameter int AW = 8
) (
    input  wire logic              i_clk,
    input  wire logic              i_we,
    input  wire logic [AW-1:0]     i_waddr,
    input  wire logic [DATA_W-1:0] i_wdata,
    input  wire logic [AW-1:0]     i_raddr_a,
    input  wire logic [AW-1:0]     i_raddr_b,
    output logic      [DATA_W-1:0] o_rdata_a,
    output logic      [DATA_W-1:0] o_rdata_b
);

    localparam int DEPTH = 1 << AW;

    logic [DATA_W-1:0] r_mem [DEPTH];
    logic [DATA_W-1:0] r_rd_a;
    logic [DATA_W-1:0] r_rd_b;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rd_a <= r_mem[i_raddr_a];
        r_rd_b <= r_mem[i_raddr_b];
    end

    assign o_rdata_a = r_rd_a;
    assign o_rdata_b = r_rd_b;

endmodule

`default_nettype wire

// ----- src/lsg_cell_update.sv -----
// cell relaxation datapath and per-sweep change accumulator
`timescale 1ns / 1ps
`default_nettype none

module lsg_cell_update import lsg_pkg::*; (
    input  wire logic                     i_clk,
    input  wire t_upd_ctl                 i_ctl,
    input  wire logic signed [DATA_W-1:0] i_rdata_a,
    input  wire logic signed [DATA_W-1:0] i_rdata_b,
    input  wire logic        [OMEGA_W-1:0] i_omega,
    output logic signed      [DATA_W-1:0] o_new,
    output logic             [CHG_W-1:0]  o_sum
);

    logic signed [DATA_W-1:0] r_u;
    logic signed [DATA_W-1:0] r_w;
    logic signed [DATA_W:0]   r_ns;
    logic signed [DATA_W+1:0] r_nsum;
    logic signed [49:0]       r_p0;
    logic signed [49:0]       r_p1;
    logic signed [DATA_W-1:0] r_v;
    logic        [CHG_W-1:0]  r_sum;

    logic signed [17:0]       coef;
    logic signed [15:0]       omega_s;
    logic signed [49:0]       prod0;
    logic signed [49:0]       prod1;
    logic signed [50:0]       acc;
    logic signed [34:0]       q;
    logic signed [DATA_W-1:0] sat;
    logic signed [DATA_W:0]   diff;
    logic        [DATA_W:0]   mag;
    logic        [CHG_W:0]    sum_ext;
    logic        [CHG_W-1:0]  sum_next;

    // 4*(1 - omega) in the same scale as omega
    assign coef    = 18'sd65536 - $signed({1'b0, i_omega, 2'b00});
    assign omega_s = $signed({1'b0, i_omega});
    assign prod0   = 50'(coef) * 50'(r_u);
    assign prod1   = 50'(omega_s) * 50'(r_nsum);

    // round half up, then floor shift
    assign acc = 51'(r_p0) + 51'(r_p1) + 51'sd32768;
    assign q   = $signed(acc[50:16]);

    always_comb begin
        if (q[34:31] == 4'b0000 || q[34:31] == 4'b1111) begin
            sat = q[DATA_W-1:0];
        end else if (q[34]) begin
            sat = {1'b1, {(DATA_W-1){1'b0}}};
        end else begin
            sat = {1'b0, {(DATA_W-1){1'b1}}};
        end
    end

    assign diff     = 33'(r_v) - 33'(r_u);
    assign mag      = diff[DATA_W] ? $unsigned(-diff) : $unsigned(diff);
    assign sum_ext  = {1'b0, r_sum} + 41'(mag);
    assign sum_next = sum_ext[CHG_W] ? CHG_MAX : sum_ext[CHG_W-1:0];

    always_ff @(posedge i_clk) begin
        if (i_ctl.cap_uw) begin
            r_u <= i_rdata_a;
            r_w <= i_rdata_b;
        end
        if (i_ctl.cap_ns) begin
            r_ns <= 33'(i_rdata_a) + 33'(i_rdata_b);
        end
        if (i_ctl.cap_e) begin
            r_nsum <= 34'(r_ns) + 34'(i_rdata_a) + 34'(r_w);
        end
        if (i_ctl.mul) begin
            r_p0 <= prod0;
            r_p1 <= prod1;
        end
        if (i_ctl.upd) begin
            r_v <= sat;
        end
        if (i_ctl.clr_sum) begin
            r_sum <= '0;
        end else if (i_ctl.acc) begin
            r_sum <= sum_next;
        end
    end

    assign o_new = r_v;
    assign o_sum = r_sum;

endmodule

`default_nettype wire

// ----- sim/laplace_sor_grid_solver_tb.sv -----
// self-checking testbench for the laplace grid engine: directed table, then random requests
`timescale 1ns / 1ps

module laplace_sor_grid_solver_tb import lsg_pkg::*; ();

    localparam int CYCLE_LIMIT = 1500000;
    localparam int RAND_PER_PHASE = 284;
    localparam logic [KIND_W-1:0] KIND_UNUSED = 2'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_NONE = 2'd3;
    localparam longint SAT_HI = 64'sd2147483647;
    localparam longint SAT_LO = -64'sd2147483648;

    typedef struct packed {
        logic signed [DATA_W-1:0] rd_value;
        logic [CNT_W-1:0]         sweeps;
        logic                     conv;
        logic [CHG_W-1:0]         change;
    } t_report;

    typedef enum logic {STEP_CMD, STEP_CFG} t_step_op;

    typedef struct packed {
        t_step_op               op;
        logic [KIND_W-1:0]      kind;
        logic [COORD_W-1:0]     col;
        logic [COORD_W-1:0]     row;
        logic [DATA_W-1:0]      value;
        logic [CFG_IDX_W-1:0]   cfg_idx;
        logic [CHG_W-1:0]       cfg_data;
        logic                   typed;
        t_report                want;
    } t_dir_step;

    logic                        i_clk;
    logic                        i_rst_n;
    logic                        start;
    logic                        busy;
    logic [KIND_W-1:0]           i_kind;
    logic [COORD_W-1:0]          i_col;
    logic [COORD_W-1:0]          i_row;
    logic signed [DATA_W-1:0]    i_cell_value;
    logic                        o_valid;
    logic signed [DATA_W-1:0]    o_read_value;
    logic [CNT_W-1:0]            o_sweeps_done;
    logic                        o_converged;
    logic [CHG_W-1:0]            o_final_change;
    logic                        i_cfg_valid;
    logic                        o_cfg_ready;
    logic [CFG_IDX_W-1:0]        i_cfg_index;
    logic [CHG_W-1:0]            i_cfg_data;

    logic signed [DATA_W-1:0] grid_mirror [DEF_ROWS][DEF_COLS];
    logic [OMEGA_W-1:0]       omega_cfg;
    logic [CNT_W-1:0]         sweep_limit;
    logic [CHG_W-1:0]         tol_cfg;
    logic [CNT_W-1:0]         last_sweeps;
    logic                     last_conv;
    logic [CHG_W-1:0]         last_change;

    t_report   pending_reports [$];
    t_dir_step dir_steps [$];
    int        err_cnt;
    int        cycle_cnt;

    laplace_sor_grid_solver #(
        .GRID_COLS(DEF_COLS),
        .GRID_ROWS(DEF_ROWS)
    ) dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .start          (start),
        .busy           (busy),
        .i_kind         (i_kind),
        .i_col          (i_col),
        .i_row          (i_row),
        .i_cell_value   (i_cell_value),
        .o_valid        (o_valid),
        .o_read_value   (o_read_value),
        .o_sweeps_done  (o_sweeps_done),
        .o_converged    (o_converged),
        .o_final_change (o_final_change),
        .i_cfg_valid    (i_cfg_valid),
        .o_cfg_ready    (o_cfg_ready),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    function automatic longint relax_cell_value(longint u, longint nsum, longint w);
        longint acc;
        acc = 4 * (16384 - w) * u + w * nsum;
        acc = (acc + 32768) >>> 16;
        if (acc > SAT_HI) begin
            acc = SAT_HI;
        end else if (acc < SAT_LO) begin
            acc = SAT_LO;
        end
        return acc;
    endfunction

    function automatic void run_sweeps();
        int unsigned n;
        logic [63:0] sum;
        bit          met;
        longint      u, ns, v, d;
        n = 0;
        sum = '0;
        met = 1'b0;
        while (n < sweep_limit) begin
            sum = '0;
            for (int r = 1; r < DEF_ROWS - 1; r++) begin
                for (int c = 1; c < DEF_COLS - 1; c++) begin
                    u = longint'(grid_mirror[r][c]);
                    ns = longint'(grid_mirror[r-1][c]) + longint'(grid_mirror[r+1][c]) +
                         longint'(grid_mirror[r][c-1]) + longint'(grid_mirror[r][c+1]);
                    v = relax_cell_value(u, ns, longint'(omega_cfg));
                    d = v - u;
                    grid_mirror[r][c] = v[DATA_W-1:0];
                    sum = sum + 64'(d < 0 ? -d : d);
                    if (sum > 64'(CHG_MAX)) begin
                        sum = 64'(CHG_MAX);
                    end
                end
            end
            n++;
            if (sum < 64'(tol_cfg)) begin
                met = 1'b1;
                break;
            end
        end
        last_sweeps = n[CNT_W-1:0];
        last_change = sum[CHG_W-1:0];
        last_conv = met;
    endfunction

    function automatic t_report predict_report(logic [KIND_W-1:0] kind, logic [COORD_W-1:0] col,
                                               logic [COORD_W-1:0] row,
                                               logic [DATA_W-1:0] value);
        t_report rep;
        bit      inside_grid;
        inside_grid = int'(col) < DEF_COLS && int'(row) < DEF_ROWS;
        rep = '0;
        if (kind == KIND_WRITE) begin
            if (inside_grid) begin
                grid_mirror[row][col] = value;
            end
        end else if (kind == KIND_SOLVE) begin
            run_sweeps();
        end else if (kind == KIND_READ) begin
            if (inside_grid) begin
                rep.rd_value = grid_mirror[row][col];
            end
        end
        rep.sweeps = last_sweeps;
        rep.conv = last_conv;
        rep.change = last_change;
        return rep;
    endfunction

    function automatic t_dir_step cmd(logic [KIND_W-1:0] kind, logic [COORD_W-1:0] col,
                                      logic [COORD_W-1:0] row, logic [DATA_W-1:0] value);
        t_dir_step step;
        step = '0;
        step.op = STEP_CMD;
        step.kind = kind;
        step.col = col;
        step.row = row;
        step.value = value;
        return step;
    endfunction

    function automatic t_dir_step cmd_chk(logic [KIND_W-1:0] kind, logic [COORD_W-1:0] col,
                                          logic [COORD_W-1:0] row, logic [DATA_W-1:0] value,
                                          logic [DATA_W-1:0] rd, logic [CNT_W-1:0] sw,
                                          logic cv, logic [CHG_W-1:0] ch);
        t_dir_step step;
        step = cmd(kind, col, row, value);
        step.typed = 1'b1;
        step.want.rd_value = rd;
        step.want.sweeps = sw;
        step.want.conv = cv;
        step.want.change = ch;
        return step;
    endfunction

    function automatic t_dir_step cfg_step(logic [CFG_IDX_W-1:0] idx, logic [CHG_W-1:0] data);
        t_dir_step step;
        step = '0;
        step.op = STEP_CFG;
        step.cfg_idx = idx;
        step.cfg_data = data;
        return step;
    endfunction

    function automatic void field_check(string what, logic [63:0] want, logic [63:0] got);
        if (want !== got) begin
            $display("%0t: %s mismatch, expected %h, actual %h", $time, what, want, got);
            err_cnt++;
        end
    endfunction

    task automatic issue_cmd(input logic [KIND_W-1:0] kind, input logic [COORD_W-1:0] col,
                             input logic [COORD_W-1:0] row, input logic [DATA_W-1:0] value,
                             input logic typed, input t_report want);
        t_report rep;
        start <= 1'b1;
        i_kind <= kind;
        i_col <= col;
        i_row <= row;
        i_cell_value <= value;
        do @(posedge i_clk); while (busy !== 1'b0);
        rep = predict_report(kind, col, row, value);
        pending_reports.push_back(typed ? want : rep);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CHG_W-1:0] data,
                             input bit more);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= data;
        do @(posedge i_clk); while (o_cfg_ready !== 1'b1);
        case (idx)
            CFG_OMEGA: omega_cfg = data[OMEGA_W-1:0];
            CFG_MAX:   sweep_limit = data[CNT_W-1:0];
            CFG_TOL:   tol_cfg = data;
            default:   ;
        endcase
        if (!more) begin
            i_cfg_valid <= 1'b0;
        end
    endtask

    task automatic drain_reports();
        if (start !== 1'b0) begin
            start <= 1'b0;
        end
        while (pending_reports.size() != 0) begin
            @(posedge i_clk);
        end
    endtask

    always @(posedge i_clk) begin
        t_report want;
        if (i_rst_n && o_valid) begin
            if (pending_reports.size() == 0) begin
                $display("%0t: result with no request waiting, actual %h %h %h %h", $time,
                         o_read_value, o_sweeps_done, o_converged, o_final_change);
                err_cnt++;
            end else begin
                want = pending_reports.pop_front();
                field_check("read_value", 64'(want.rd_value), 64'(o_read_value));
                field_check("sweeps_done", 64'(want.sweeps), 64'(o_sweeps_done));
                field_check("converged", 64'(want.conv), 64'(o_converged));
                field_check("final_change", 64'(want.change), 64'(o_final_change));
            end
        end
    end

    initial begin
        cycle_cnt = 0;
        while (cycle_cnt < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_cnt++;
        end
        $display("%0t: timeout", $time);
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    initial begin
        int unsigned       pick;
        int unsigned       idle_pct;
        bit                more;
        logic [KIND_W-1:0] kind;
        logic [COORD_W-1:0] col;
        logic [COORD_W-1:0] row;
        logic [DATA_W-1:0] val;
        logic [CHG_W-1:0]  tol_val;
        logic [CHG_W-1:0]  omega_val;
        logic [CHG_W-1:0]  max_val;

        start <= 1'b0;
        i_kind <= KIND_WRITE;
        i_col <= '0;
        i_row <= '0;
        i_cell_value <= '0;
        i_cfg_valid <= 1'b0;
        i_cfg_index <= CFG_OMEGA;
        i_cfg_data <= '0;
        i_rst_n <= 1'b0;
        err_cnt = 0;
        foreach (grid_mirror[r, c]) begin
            grid_mirror[r][c] = '0;
        end
        omega_cfg = OMEGA_RST;
        sweep_limit = MAX_RST;
        tol_cfg = TOL_RST;
        last_sweeps = '0;
        last_conv = 1'b0;
        last_change = '0;

        dir_steps = '{
            cmd_chk(KIND_READ, 4'd0, 4'd0, 32'h0, 32'h0, 16'd0, 1'b0, 40'd0),
            cmd_chk(KIND_UNUSED, 4'd15, 4'd15, 32'hFFFFFFFF, 32'h0, 16'd0, 1'b0, 40'd0),
            cmd_chk(KIND_SOLVE, 4'd0, 4'd0, 32'h0, 32'h0, 16'd1, 1'b1, 40'd0),
            cmd_chk(KIND_WRITE, 4'd0, 4'd0, 32'h7FFFFFFF, 32'h0, 16'd1, 1'b1, 40'd0),
            cmd_chk(KIND_READ, 4'd0, 4'd0, 32'h0, 32'h7FFFFFFF, 16'd1, 1'b1, 40'd0),
            cmd_chk(KIND_WRITE, 4'd15, 4'd15, 32'h80000000, 32'h0, 16'd1, 1'b1, 40'd0),
            cmd_chk(KIND_READ, 4'd15, 4'd15, 32'h0, 32'h80000000, 16'd1, 1'b1, 40'd0),
            cfg_step(CFG_MAX, 40'd0),
            cmd_chk(KIND_SOLVE, 4'd0, 4'd0, 32'h0, 32'h0, 16'd0, 1'b0, 40'd0),
            cfg_step(CFG_OMEGA, 40'd32767),
            cfg_step(CFG_MAX, 40'd2),
            cfg_step(CFG_TOL, 40'd0),
            cmd(KIND_WRITE, 4'd7, 4'd0, 32'h7FFFFFFF),
            cmd(KIND_WRITE, 4'd7, 4'd5, 32'h80000000),
            cmd(KIND_WRITE, 4'd8, 4'd6, 32'h7FFFFFFF),
            cmd(KIND_WRITE, 4'd14, 4'd14, 32'h00018000),
            cmd(KIND_SOLVE, 4'd0, 4'd0, 32'h0),
            cmd(KIND_READ, 4'd7, 4'd5, 32'h0),
            cmd(KIND_READ, 4'd14, 4'd14, 32'h0),
            cfg_step(CFG_OMEGA, 40'd0),
            cfg_step(CFG_TOL, CHG_MAX),
            cfg_step(CFG_MAX, 40'd65535),
            cmd_chk(KIND_SOLVE, 4'd0, 4'd0, 32'h0, 32'h0, 16'd1, 1'b1, 40'd0),
            cmd_chk(KIND_UNUSED, 4'd3, 4'd9, 32'h0, 32'h0, 16'd1, 1'b1, 40'd0),
            cfg_step(CFG_OMEGA, 40'd16384),
            cfg_step(CFG_MAX, 40'd1),
            cfg_step(CFG_NONE, 40'd0),
            cmd(KIND_SOLVE, 4'd0, 4'd0, 32'h0),
            cmd(KIND_READ, 4'd8, 4'd6, 32'h0)
        };

        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        for (int i = 0; i < dir_steps.size(); i++) begin
            if (dir_steps[i].op == STEP_CFG) begin
                more = (i + 1 < dir_steps.size()) && (dir_steps[i+1].op == STEP_CFG);
                drain_reports();
                write_reg(dir_steps[i].cfg_idx, dir_steps[i].cfg_data, more);
            end else begin
                issue_cmd(dir_steps[i].kind, dir_steps[i].col, dir_steps[i].row,
                          dir_steps[i].value, dir_steps[i].typed, dir_steps[i].want);
            end
        end

        for (int phase = 0; phase < 3; phase++) begin
            // solves stay short: few sweeps per request
            case (phase)
                0: begin
                    omega_val = 40'($urandom_range(32767));
                    max_val = 40'($urandom_range(4, 1));
                    tol_val = 40'({$urandom, $urandom} >> $urandom_range(60, 24));
                    idle_pct = 8;
                end
                1: begin
                    omega_val = 40'($urandom_range(20000, 12000));
                    max_val = 40'($urandom_range(3, 1));
                    tol_val = {8'($urandom_range(255)), 32'($urandom)};
                    idle_pct = 70;
                end
                default: begin
                    omega_val = 40'($urandom_range(32767, 24000));
                    max_val = 40'd4;
                    tol_val = '0;
                    idle_pct = 0;
                end
            endcase
            drain_reports();
            write_reg(CFG_OMEGA, omega_val, 1'b1);
            write_reg(CFG_MAX, max_val, 1'b1);
            write_reg(CFG_TOL, tol_val, 1'b0);

            for (int n = 0; n < RAND_PER_PHASE; n++) begin
                pick = $urandom_range(99);
                if (pick < 48) begin
                    kind = KIND_WRITE;
                end else if (pick < 91) begin
                    kind = KIND_READ;
                end else if (pick < 96) begin
                    kind = KIND_SOLVE;
                end else begin
                    kind = KIND_UNUSED;
                end
                col = 4'($urandom);
                row = 4'($urandom);
                case ($urandom_range(3))
                    0: val = $urandom;
                    1: val = $urandom_range(2097152) - 32'd1048576;
                    2: begin
                        case ($urandom_range(3))
                            0: val = 32'h7FFFFFFF;
                            1: val = 32'h80000000;
                            2: val = 32'h0;
                            default: val = 32'hFFFFFFFF;
                        endcase
                    end
                    default: val = $urandom_range(33554432) - 32'd16777216;
                endcase
                issue_cmd(kind, col, row, val, 1'b0, '0);
                if ($urandom_range(99) < idle_pct) begin
                    start <= 1'b0;
                    do @(posedge i_clk); while ($urandom_range(99) < idle_pct);
                end
                if ($urandom_range(199) == 0) begin
                    drain_reports();
                end
            end
        end

        drain_reports();
        repeat (20) @(posedge i_clk);
        if (err_cnt == 0 && pending_reports.size() == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule
